@@ rtl/saa_pkg.sv @@
`timescale 1ns / 1ps
// saa_pkg: shared types and constants of the sensor axis alignment block.
// No dependencies.
package saa_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int COEFF_W             = 16;
    localparam int ROW_W               = 3 * COEFF_W;
    localparam int CFG_INDEX_W         = 3;
    localparam int COEFF_FRAC_BITS_DEF = 14;

    // Identity rows after reset: 1.0 in Q2.14 on the diagonal
    localparam logic [ROW_W-1:0] ROLL_RESET  = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] PITCH_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] YAW_RESET   = 48'h4000_0000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIENT,
        CFG_BYPASS,
        CFG_ROLL,
        CFG_PITCH,
        CFG_YAW
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ORIENT_CW0,
        ORIENT_CW90,
        ORIENT_CW180,
        ORIENT_CW270,
        ORIENT_CW0_FLIP,
        ORIENT_CW90_FLIP,
        ORIENT_CW180_FLIP,
        ORIENT_CW270_FLIP
    } orient_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] axis_x;
        logic signed [SAMPLE_W-1:0] axis_y;
        logic signed [SAMPLE_W-1:0] axis_z;
    } saa_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] roll_out;
        logic signed [SAMPLE_W-1:0] pitch_out;
        logic signed [SAMPLE_W-1:0] yaw_out;
        logic                       clipped;
    } saa_out_t;

endpackage

@@ rtl/saa_rotate_row.sv @@
`timescale 1ns / 1ps
// saa_rotate_row: one row of the 3x3 rotation, products then sum, then
// round-half-even and saturation. Depends on saa_pkg.
module saa_rotate_row #(
    parameter int FRAC_BITS = saa_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [saa_pkg::ROW_W-1:0]           coeffs,
    input  logic signed [saa_pkg::SAMPLE_W-1:0] x,
    input  logic signed [saa_pkg::SAMPLE_W-1:0] y,
    input  logic signed [saa_pkg::SAMPLE_W-1:0] z,
    output logic signed [saa_pkg::SAMPLE_W-1:0] result,
    output logic                                clip
);
    import saa_pkg::*;

    localparam int PROD_W = SAMPLE_W + COEFF_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [SUM_W:0] MAX_V = 32767;
    localparam logic signed [SUM_W:0] MIN_V = -32768;

    logic signed [COEFF_W-1:0] cx, cy, cz;
    logic signed [PROD_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [PROD_W-1:0]  px_next, py_next, pz_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [SUM_W-1:0]   quot;
    logic [FRAC_BITS-1:0]      rem;
    logic                      round_up;
    logic signed [SUM_W:0]     rounded;

    assign cx = coeffs[COEFF_W-1:0];
    assign cy = coeffs[2*COEFF_W-1:COEFF_W];
    assign cz = coeffs[3*COEFF_W-1:2*COEFF_W];

    assign px_next = cx * x;
    assign py_next = cy * y;
    assign pz_next = cz * z;

    assign sum_next = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
            sum_reg <= sum_next;
        end
    end

    // floor division, then ties to even
    assign quot     = sum_reg >>> FRAC_BITS;
    assign rem      = sum_reg[FRAC_BITS-1:0];
    assign round_up = (rem > HALF) || ((rem == HALF) && quot[0]);
    assign rounded  = {quot[SUM_W-1], quot} + {{SUM_W{1'b0}}, round_up};

    always_comb
    begin
        if (rounded > MAX_V)
        begin
            result = 16'sh7fff;
            clip   = 1'b1;
        end
        else if (rounded < MIN_V)
        begin
            result = -16'sh8000;
            clip   = 1'b1;
        end
        else
        begin
            result = rounded[SAMPLE_W-1:0];
            clip   = 1'b0;
        end
    end

endmodule

@@ rtl/sensor_axis_alignment.sv @@
`timescale 1ns / 1ps
// sensor_axis_alignment: orientation remap and optional 3x3 board rotation
// of a three-axis sample. Depends on saa_pkg and saa_rotate_row.
//
// A sample transfer is taken every cycle while in_stall is low; its result is
// registered after remap, products, sum and round/saturate into the output register.
// The whole pipeline holds while a result waits under out_stall, so
// in_stall follows out_stall. Configuration is written through cfg_write,
// cfg_index and cfg_data and should change only while the pipeline is empty.
module sensor_axis_alignment #(
    parameter int COEFF_FRAC_BITS = saa_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  saa_pkg::saa_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output saa_pkg::saa_out_t               out_data,
    input  logic                            cfg_write,
    input  logic [saa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [saa_pkg::ROW_W-1:0]       cfg_data
);
    import saa_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        logic                       clip;
    } vec_t;

    orient_t          orient_reg;
    logic             bypass_reg;
    logic [ROW_W-1:0] roll_reg, pitch_reg, yaw_reg;

    logic     en;
    logic     v1_reg, v2_reg, v3_reg, out_valid_reg;
    vec_t     s1_reg, s2_reg, s3_reg, s1_next;
    saa_out_t out_reg, out_next;

    logic signed [SAMPLE_W-1:0] r_roll, r_pitch, r_yaw;
    logic                       c_roll, c_pitch, c_yaw;

    function automatic logic signed [SAMPLE_W-1:0] neg_sat(
        input logic signed [SAMPLE_W-1:0] v
    );
        if (v == -16'sh8000)
            return 16'sh7fff;
        return -v;
    endfunction

    function automatic logic is_min(input logic signed [SAMPLE_W-1:0] v);
        return v == -16'sh8000;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= ORIENT_CW0;
            bypass_reg <= 1'b1;
            roll_reg   <= ROLL_RESET;
            pitch_reg  <= PITCH_RESET;
            yaw_reg    <= YAW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ORIENT: orient_reg <= orient_t'(cfg_data[2:0]);
                CFG_BYPASS: bypass_reg <= cfg_data[0];
                CFG_ROLL:   roll_reg   <= cfg_data;
                CFG_PITCH:  pitch_reg  <= cfg_data;
                CFG_YAW:    yaw_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        s1_next = '0;
        case (orient_reg)
            ORIENT_CW0:
            begin
                s1_next.x = in_data.axis_x;
                s1_next.y = in_data.axis_y;
                s1_next.z = in_data.axis_z;
            end
            ORIENT_CW90:
            begin
                s1_next.x    = in_data.axis_y;
                s1_next.y    = neg_sat(in_data.axis_x);
                s1_next.z    = in_data.axis_z;
                s1_next.clip = is_min(in_data.axis_x);
            end
            ORIENT_CW180:
            begin
                s1_next.x    = neg_sat(in_data.axis_x);
                s1_next.y    = neg_sat(in_data.axis_y);
                s1_next.z    = in_data.axis_z;
                s1_next.clip = is_min(in_data.axis_x) || is_min(in_data.axis_y);
            end
            ORIENT_CW270:
            begin
                s1_next.x    = neg_sat(in_data.axis_y);
                s1_next.y    = in_data.axis_x;
                s1_next.z    = in_data.axis_z;
                s1_next.clip = is_min(in_data.axis_y);
            end
            ORIENT_CW0_FLIP:
            begin
                s1_next.x    = neg_sat(in_data.axis_x);
                s1_next.y    = in_data.axis_y;
                s1_next.z    = neg_sat(in_data.axis_z);
                s1_next.clip = is_min(in_data.axis_x) || is_min(in_data.axis_z);
            end
            ORIENT_CW90_FLIP:
            begin
                s1_next.x    = in_data.axis_y;
                s1_next.y    = in_data.axis_x;
                s1_next.z    = neg_sat(in_data.axis_z);
                s1_next.clip = is_min(in_data.axis_z);
            end
            ORIENT_CW180_FLIP:
            begin
                s1_next.x    = in_data.axis_x;
                s1_next.y    = neg_sat(in_data.axis_y);
                s1_next.z    = neg_sat(in_data.axis_z);
                s1_next.clip = is_min(in_data.axis_y) || is_min(in_data.axis_z);
            end
            default:
            begin
                s1_next.x    = neg_sat(in_data.axis_y);
                s1_next.y    = neg_sat(in_data.axis_x);
                s1_next.z    = neg_sat(in_data.axis_z);
                s1_next.clip = is_min(in_data.axis_x) || is_min(in_data.axis_y)
                               || is_min(in_data.axis_z);
            end
        endcase
    end

    saa_rotate_row #(.FRAC_BITS(COEFF_FRAC_BITS)) u_row_roll (
        .clk    (clk),
        .en     (en),
        .coeffs (roll_reg),
        .x      (s1_reg.x),
        .y      (s1_reg.y),
        .z      (s1_reg.z),
        .result (r_roll),
        .clip   (c_roll)
    );

    saa_rotate_row #(.FRAC_BITS(COEFF_FRAC_BITS)) u_row_pitch (
        .clk    (clk),
        .en     (en),
        .coeffs (pitch_reg),
        .x      (s1_reg.x),
        .y      (s1_reg.y),
        .z      (s1_reg.z),
        .result (r_pitch),
        .clip   (c_pitch)
    );

    saa_rotate_row #(.FRAC_BITS(COEFF_FRAC_BITS)) u_row_yaw (
        .clk    (clk),
        .en     (en),
        .coeffs (yaw_reg),
        .x      (s1_reg.x),
        .y      (s1_reg.y),
        .z      (s1_reg.z),
        .result (r_yaw),
        .clip   (c_yaw)
    );

    always_comb
    begin
        if (bypass_reg)
        begin
            out_next.roll_out  = s3_reg.x;
            out_next.pitch_out = s3_reg.y;
            out_next.yaw_out   = s3_reg.z;
            out_next.clipped   = s3_reg.clip;
        end
        else
        begin
            out_next.roll_out  = r_roll;
            out_next.pitch_out = r_pitch;
            out_next.yaw_out   = r_yaw;
            out_next.clipped   = s3_reg.clip || c_roll || c_pitch || c_yaw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s1_reg;
            s3_reg  <= s2_reg;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ dv/tb_sensor_axis_alignment.sv @@
`timescale 1ns / 1ps
// tb_sensor_axis_alignment: self-checking bench for sensor_axis_alignment, with a
// scoreboard that predicts each remapped and rotated sample from its own register copy.
// Depends on saa_pkg and the sensor_axis_alignment RTL.
module tb_sensor_axis_alignment;

    import saa_pkg::*;

    localparam int  FRAC        = COEFF_FRAC_BITS_DEF;
    localparam int  SETTLE_CYC  = 8;
    localparam int  LONG_HOLD   = 80;
    localparam int  RAND_PHASES = 8;
    localparam int  PHASE_ITEMS = 100;
    localparam int  MAX_REPORTS = 10;
    localparam longint TIMEOUT_NS = 10_000_000;

    class alignment_scoreboard;
        orient_t          orient;
        bit               bypass;
        logic [ROW_W-1:0] row [3];
        saa_out_t         aligned_q [$];
        int               errors;

        function new();
            orient = ORIENT_CW0;
            bypass = 1'b1;
            row[0] = ROLL_RESET;
            row[1] = PITCH_RESET;
            row[2] = YAW_RESET;
            errors = 0;
        endfunction

        function void apply_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [ROW_W-1:0] d);
            case (idx)
                CFG_ORIENT: orient = orient_t'(d[2:0]);
                CFG_BYPASS: bypass = d[0];
                CFG_ROLL:   row[0] = d;
                CFG_PITCH:  row[1] = d;
                CFG_YAW:    row[2] = d;
                default:    ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] neg_sat(input logic signed [SAMPLE_W-1:0] v,
                                                     inout bit clip);
            if (v == 16'sh8000)
            begin
                clip = 1'b1;
                return 16'sh7FFF;
            end
            return -v;
        endfunction

        function logic signed [SAMPLE_W-1:0] rotate(input logic [ROW_W-1:0] c,
                                                    input logic signed [SAMPLE_W-1:0] x,
                                                    input logic signed [SAMPLE_W-1:0] y,
                                                    input logic signed [SAMPLE_W-1:0] z,
                                                    inout bit clip);
            longint acc;
            longint q;
            longint rem;
            longint half;
            half = longint'(1) <<< (FRAC - 1);
            acc = longint'($signed(c[15:0])) * x + longint'($signed(c[31:16])) * y
                + longint'($signed(c[47:32])) * z;
            q = acc >>> FRAC;
            rem = acc - (q <<< FRAC);
            if (rem > half || (rem == half && q[0]))
                q++;
            if (q > 32767)
            begin
                clip = 1'b1;
                return 16'sh7FFF;
            end
            if (q < -32768)
            begin
                clip = 1'b1;
                return 16'sh8000;
            end
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_sample(input saa_in_t s);
            logic signed [SAMPLE_W-1:0] x;
            logic signed [SAMPLE_W-1:0] y;
            logic signed [SAMPLE_W-1:0] z;
            bit       clip;
            saa_out_t e;
            clip = 1'b0;
            case (orient)
                ORIENT_CW0:
                begin
                    x = s.axis_x; y = s.axis_y; z = s.axis_z;
                end
                ORIENT_CW90:
                begin
                    x = s.axis_y; y = neg_sat(s.axis_x, clip); z = s.axis_z;
                end
                ORIENT_CW180:
                begin
                    x = neg_sat(s.axis_x, clip); y = neg_sat(s.axis_y, clip); z = s.axis_z;
                end
                ORIENT_CW270:
                begin
                    x = neg_sat(s.axis_y, clip); y = s.axis_x; z = s.axis_z;
                end
                ORIENT_CW0_FLIP:
                begin
                    x = neg_sat(s.axis_x, clip); y = s.axis_y; z = neg_sat(s.axis_z, clip);
                end
                ORIENT_CW90_FLIP:
                begin
                    x = s.axis_y; y = s.axis_x; z = neg_sat(s.axis_z, clip);
                end
                ORIENT_CW180_FLIP:
                begin
                    x = s.axis_x; y = neg_sat(s.axis_y, clip); z = neg_sat(s.axis_z, clip);
                end
                default:
                begin
                    x = neg_sat(s.axis_y, clip);
                    y = neg_sat(s.axis_x, clip);
                    z = neg_sat(s.axis_z, clip);
                end
            endcase
            if (!bypass)
            begin
                e.roll_out  = rotate(row[0], x, y, z, clip);
                e.pitch_out = rotate(row[1], x, y, z, clip);
                e.yaw_out   = rotate(row[2], x, y, z, clip);
            end
            else
            begin
                e.roll_out  = x;
                e.pitch_out = y;
                e.yaw_out   = z;
            end
            e.clipped = clip;
            aligned_q.push_back(e);
        endfunction

        function void check_result(input saa_out_t got);
            saa_out_t e;
            if (aligned_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected transfer: roll %0d pitch %0d yaw %0d clip %0b",
                             got.roll_out, got.pitch_out, got.yaw_out, got.clipped);
                return;
            end
            e = aligned_q.pop_front();
            if (got.roll_out !== e.roll_out || got.pitch_out !== e.pitch_out
                || got.yaw_out !== e.yaw_out || got.clipped !== e.clipped)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display(
                        "mismatch: exp %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
                        e.roll_out, e.pitch_out, e.yaw_out, e.clipped,
                        got.roll_out, got.pitch_out, got.yaw_out, got.clipped);
            end
        endfunction

        function int pending();
            return aligned_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    saa_in_t                in_data;
    logic                   out_valid;
    logic                   out_stall;
    saa_out_t               out_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ROW_W-1:0]       cfg_data;

    alignment_scoreboard sb;
    bit offering;
    bit steady;
    int burst_left;

    sensor_axis_alignment i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic saa_in_t mk_sample(input int x, input int y, input int z);
        saa_in_t s;
        s.axis_x = x[SAMPLE_W-1:0];
        s.axis_y = y[SAMPLE_W-1:0];
        s.axis_z = z[SAMPLE_W-1:0];
        return s;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_axis();
        if ($urandom_range(0, 3) != 0)
            return 16'($urandom());
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] rand_coeff(input int kind);
        case (kind)
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 32768)) - 16'd16384;
            default:
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'h4000;
                    default: return 16'hC000;
                endcase
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] wide_rand();
        return {16'($urandom()), $urandom()};
    endfunction

    task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [ROW_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.apply_cfg(idx, d);
    endtask

    task automatic cfg_close(input bit junk);
        if (junk)
            for (int j = int'(CFG_YAW) + 1; j < (1 << CFG_INDEX_W); j++)
                cfg_put(CFG_INDEX_W'(j), wide_rand());
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input saa_in_t s);
        int gap;
        in_valid <= 1'b1;
        in_data  <= s;
        offering = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(s);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // drop valid, then wait until every transfer is back and the pipe is empty
    task automatic settle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // receiver: stall patterns in random stretches, plus two long hold-offs
    initial
    begin
        int mode;
        int mode_left;
        int seen;
        int hold_left;
        int cyc;
        mode = 0;
        mode_left = 0;
        seen = 0;
        hold_left = 0;
        cyc = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result(out_data);
                seen++;
                if (seen == 120 || seen == 520)
                    hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            cyc++;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= (cyc % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    initial
    begin
        logic [ROW_W-1:0] d;
        logic [ROW_W-1:0] r;
        int kind;
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        offering = 1'b0;
        steady = 1'b0;
        burst_left = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: straight through
        send_sample(mk_sample(0, 0, 0));
        send_sample(mk_sample(32767, -32768, 1));
        send_sample(mk_sample(-32768, -32768, -32768));
        settle();

        // identity matrix from reset
        cfg_put(CFG_BYPASS, '0);
        cfg_close(1'b0);
        send_sample(mk_sample(-32768, 32767, -1));
        send_sample(mk_sample(12345, -23456, -1));
        settle();

        // every orientation; upper data bits carry junk, negation of the minimum clips
        cfg_put(CFG_BYPASS, 48'h1);
        cfg_close(1'b0);
        for (int o = int'(ORIENT_CW0); o <= int'(ORIENT_CW270_FLIP); o++)
        begin
            d = wide_rand();
            d[2:0] = o[2:0];
            cfg_put(CFG_ORIENT, d);
            cfg_close(1'b0);
            send_sample(mk_sample(-32768, -32767, -32766));
            settle();
        end

        // ties to even on half coefficients, overflow both ways, unused indexes ignored
        cfg_put(CFG_ORIENT, ROW_W'(ORIENT_CW0));
        cfg_put(CFG_BYPASS, '0);
        cfg_put(CFG_ROLL, 48'h0000_0000_2000);
        cfg_put(CFG_PITCH, {3{16'h7FFF}});
        cfg_put(CFG_YAW, {3{16'h8000}});
        cfg_close(1'b1);
        send_sample(mk_sample(1, 0, 0));
        send_sample(mk_sample(3, 32767, 32767));
        send_sample(mk_sample(-1, 0, 0));
        send_sample(mk_sample(-3, -32768, -32768));
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            cfg_put(CFG_ORIENT, wide_rand());
            d = wide_rand();
            d[0] = (p == 2) || ($urandom_range(0, 3) == 0);
            cfg_put(CFG_BYPASS, d);
            kind = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++)
            begin
                if (p == 0)
                    r = {3{16'h7FFF}};
                else if (p == 1)
                    r = {3{16'h8000}};
                else
                    r = {rand_coeff(kind), rand_coeff(kind), rand_coeff(kind)};
                cfg_put(CFG_INDEX_W'(int'(CFG_ROLL) + k), r);
            end
            cfg_close(1'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                saa_in_t s;
                s.axis_x = rand_axis();
                s.axis_y = rand_axis();
                s.axis_z = rand_axis();
                send_sample(s);
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
